FILE: hdl/boxdec_pkg.sv
// boxdec_pkg: frame geometry, field widths and stage payload types of the
// 5x5 box-average decimator. Depends on nothing; used by every other file.
`default_nettype none

package boxdec_pkg;

   // frame geometry
   localparam int unsigned IN_COLS  = 164;
   localparam int unsigned IN_ROWS  = 122;
   localparam int unsigned OUT_COLS = 32;
   localparam int unsigned OUT_ROWS = 24;
   localparam int unsigned BLOCK_W  = 5;
   localparam int unsigned BLOCK_H  = 5;

   localparam int unsigned SPAN_X = OUT_COLS * BLOCK_W;
   localparam int unsigned SPAN_Y = OUT_ROWS * BLOCK_H;
   localparam int unsigned TRIM_X = (SPAN_X >= IN_COLS) ? 0 : (IN_COLS - SPAN_X) / 2;
   localparam int unsigned TRIM_Y = (SPAN_Y >= IN_ROWS) ? 0 : (IN_ROWS - SPAN_Y) / 2;

   // field widths
   localparam int unsigned PIXEL_W   = 8;
   localparam int unsigned LEVEL_W   = 16;
   localparam int unsigned SUM_W     = 13;
   localparam int unsigned OUT_COL_W = 5;
   localparam int unsigned OUT_ROW_W = 5;

   // counter widths
   localparam int unsigned COL_W = (IN_COLS > 1) ? $clog2(IN_COLS) : 1;
   localparam int unsigned ROW_W = (IN_ROWS > 1) ? $clog2(IN_ROWS) : 1;
   localparam int unsigned IX_W  = (BLOCK_W > 1) ? $clog2(BLOCK_W) : 1;
   localparam int unsigned IY_W  = (BLOCK_H > 1) ? $clog2(BLOCK_H) : 1;

   // level = round(sum * 2^16 / FULL_SCALE) by an exact reciprocal multiply
   localparam int unsigned FULL_SCALE  = BLOCK_W * BLOCK_H * 255;
   localparam int unsigned HALF_SCALE  = FULL_SCALE / 2;
   localparam int unsigned NUM_W       = SUM_W + LEVEL_W;
   localparam int unsigned RECIP_SHIFT = 42;
   localparam int unsigned RECIP_W     = 30;
   localparam logic [63:0] RECIP_64    =
      ((64'd1 << RECIP_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_64);
   localparam int unsigned PROD_W      = NUM_W + RECIP_W;
   localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;

   // decoded pixel between position stage and accumulator stage
   typedef struct packed {
      logic [PIXEL_W-1:0]   pixel;
      logic                 in_window;
      logic                 first;
      logic                 last;
      logic                 last_of_frame;
      logic [OUT_COL_W-1:0] bx;
      logic [OUT_ROW_W-1:0] by;
   } pix_type;

   // finished block between accumulator stage and level stage
   typedef struct packed {
      logic [SUM_W-1:0]     block_sum;
      logic [OUT_COL_W-1:0] bx;
      logic [OUT_ROW_W-1:0] by;
      logic                 last_of_frame;
   } blk_type;

endpackage

`default_nettype wire

FILE: hdl/boxdec_if.sv
// boxdec_req_if, boxdec_rsp_if: valid/ready channels for pixels in and
// block results out. Depends on boxdec_pkg for field widths.
`default_nettype none

interface boxdec_req_if import boxdec_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   logic               frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface boxdec_rsp_if import boxdec_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [LEVEL_W-1:0]   level;
   logic [SUM_W-1:0]     block_sum;
   logic [OUT_COL_W-1:0] out_col;
   logic [OUT_ROW_W-1:0] out_row;
   logic                 last_of_frame;

   modport source (output valid, output level, output block_sum, output out_col,
                   output out_row, output last_of_frame, input ready);
   modport sink   (input valid, input level, input block_sum, input out_col,
                   input out_row, input last_of_frame, output ready);
endinterface

`default_nettype wire

FILE: hdl/box_average_decimator_core.sv
// Box-average decimator: takes a 164 x 122 raster frame of 8-bit pixels, trims
// 2 columns on each side and 1 row top and bottom, and sums each 5 x 5 block
// into a 32 x 24 image. One pixel is taken every clock cycle; stalls on the
// result side hold the pipe. A block result (sum, level, position) passes
// from the transfer of the block's last pixel through the position register,
// the accumulator read-modify-write and the level multiply, each one stage.
// Border pixels and pixels that do not close a block give no result.
// frame_start on a pixel restarts the position counters at that pixel.
`default_nettype none

module box_average_decimator_core import boxdec_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   boxdec_req_if.sink   req_ch,
   boxdec_rsp_if.source rsp_ch
);

   logic    pix_valid, pix_ready;
   pix_type pix_data;
   logic    blk_valid, blk_ready;
   blk_type blk_data;

   boxdec_position u_position (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .pix_valid (pix_valid),
      .pix_ready (pix_ready),
      .pix_data  (pix_data)
   );

   boxdec_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .pix_valid (pix_valid),
      .pix_ready (pix_ready),
      .pix_data  (pix_data),
      .blk_valid (blk_valid),
      .blk_ready (blk_ready),
      .blk_data  (blk_data)
   );

   boxdec_level u_level (
      .clock     (clock),
      .reset     (reset),
      .blk_valid (blk_valid),
      .blk_ready (blk_ready),
      .blk_data  (blk_data),
      .rsp_ch    (rsp_ch)
   );

   // a block never holds more than its own pixels
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (32'(rsp_ch.block_sum) <= FULL_SCALE))
      else $error("block sum above full scale");

   // frame end flag only on the bottom right block
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.last_of_frame) |->
         ((32'(rsp_ch.out_col) == OUT_COLS - 1) && (32'(rsp_ch.out_row) == OUT_ROWS - 1)))
      else $error("last_of_frame on wrong block");

   // level end points follow the sum
   a_level_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |->
         ((rsp_ch.block_sum == '0) == (rsp_ch.level == '0))
         && ((32'(rsp_ch.block_sum) == FULL_SCALE) == (rsp_ch.level == '1)))
      else $error("level out of step with block sum");

   // a finished block reaches the result register when that stage moves
   a_blk_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (blk_valid && blk_ready) |=> rsp_ch.valid)
      else $error("block result lost before the output register");

endmodule

`default_nettype wire

FILE: hdl/boxdec_position.sv
// boxdec_position: raster position counters, trim window and block decode;
// registers each pixel with its block flags. Depends on boxdec_pkg, boxdec_req_if.
`default_nettype none

module boxdec_position import boxdec_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   boxdec_req_if.sink req_ch,
   output logic       pix_valid,
   input  logic       pix_ready,
   output pix_type    pix_data
);

   logic [COL_W-1:0]     col_ff, col_in, cur_col, nxt_col;
   logic [ROW_W-1:0]     row_ff, row_in, cur_row, nxt_row;
   logic [IX_W-1:0]      ix_ff, ix_in, cur_ix;
   logic [IY_W-1:0]      iy_ff, iy_in, cur_iy;
   logic [OUT_COL_W-1:0] bx_ff, bx_in, cur_bx;
   logic [OUT_ROW_W-1:0] by_ff, by_in, cur_by;
   logic                 in_x, in_y, col_end, row_end, ix_end, iy_end;
   logic                 valid_ff;
   pix_type              data_ff, data_in;
   logic                 accept;

   assign req_ch.ready = !valid_ff || pix_ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign pix_valid    = valid_ff;
   assign pix_data     = data_ff;

   always_comb begin
      // frame_start puts the counters at zero before this pixel is placed
      cur_col = req_ch.frame_start ? '0 : col_ff;
      cur_row = req_ch.frame_start ? '0 : row_ff;
      cur_ix  = req_ch.frame_start ? '0 : ix_ff;
      cur_iy  = req_ch.frame_start ? '0 : iy_ff;
      cur_bx  = req_ch.frame_start ? '0 : bx_ff;
      cur_by  = req_ch.frame_start ? '0 : by_ff;

      in_x    = (32'(cur_col) >= TRIM_X) && (32'(cur_col) < TRIM_X + SPAN_X);
      in_y    = (32'(cur_row) >= TRIM_Y) && (32'(cur_row) < TRIM_Y + SPAN_Y);
      col_end = (32'(cur_col) == IN_COLS - 1);
      row_end = (32'(cur_row) == IN_ROWS - 1);
      ix_end  = (32'(cur_ix) == BLOCK_W - 1);
      iy_end  = (32'(cur_iy) == BLOCK_H - 1);
      nxt_col = col_end ? '0 : cur_col + COL_W'(1);
      nxt_row = row_end ? '0 : cur_row + ROW_W'(1);

      col_in = nxt_col;
      row_in = cur_row;
      ix_in  = cur_ix;
      bx_in  = cur_bx;
      iy_in  = cur_iy;
      by_in  = cur_by;

      // block column tracking inside the trimmed window
      if (32'(nxt_col) == TRIM_X) begin
         ix_in = '0;
         bx_in = '0;
      end else if (in_x) begin
         if (ix_end) begin
            ix_in = '0;
            bx_in = cur_bx + OUT_COL_W'(1);
         end else begin
            ix_in = cur_ix + IX_W'(1);
         end
      end

      // block row tracking, once per line
      if (col_end) begin
         row_in = nxt_row;
         if (32'(nxt_row) == TRIM_Y) begin
            iy_in = '0;
            by_in = '0;
         end else if (in_y) begin
            if (iy_end) begin
               iy_in = '0;
               by_in = cur_by + OUT_ROW_W'(1);
            end else begin
               iy_in = cur_iy + IY_W'(1);
            end
         end
      end

      data_in.pixel         = req_ch.pixel;
      data_in.in_window     = in_x && in_y;
      data_in.first         = (cur_ix == '0) && (cur_iy == '0);
      data_in.last          = ix_end && iy_end;
      data_in.last_of_frame = ix_end && iy_end
                              && (32'(cur_bx) == OUT_COLS - 1)
                              && (32'(cur_by) == OUT_ROWS - 1);
      data_in.bx            = cur_bx;
      data_in.by            = cur_by;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         ix_ff    <= '0;
         iy_ff    <= '0;
         bx_ff    <= '0;
         by_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            valid_ff <= req_ch.valid;
         end
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
            ix_ff  <= ix_in;
            iy_ff  <= iy_in;
            bx_ff  <= bx_in;
            by_ff  <= by_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/boxdec_accum.sv
// boxdec_accum: one accumulator per block column, updated read-modify-write;
// passes finished block sums on. Depends on boxdec_pkg.
`default_nettype none

module boxdec_accum import boxdec_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    pix_valid,
   output logic    pix_ready,
   input  pix_type pix_data,
   output logic    blk_valid,
   input  logic    blk_ready,
   output blk_type blk_data
);

   logic [SUM_W-1:0] acc_ff [OUT_COLS];
   logic [SUM_W-1:0] acc_rd, sum_in;
   logic             valid_ff;
   blk_type          data_ff, data_in;
   logic             xfer;

   assign pix_ready = !valid_ff || blk_ready;
   assign xfer      = pix_valid && pix_ready;
   assign blk_valid = valid_ff;
   assign blk_data  = data_ff;

   always_comb begin
      acc_rd = acc_ff[pix_data.bx];
      // first pixel of a block starts the sum fresh
      sum_in = pix_data.first ? SUM_W'(pix_data.pixel)
                              : acc_rd + SUM_W'(pix_data.pixel);
      data_in.block_sum     = sum_in;
      data_in.bx            = pix_data.bx;
      data_in.by            = pix_data.by;
      data_in.last_of_frame = pix_data.last_of_frame;
   end

   always_ff @(posedge clock) begin
      if (xfer && pix_data.in_window) begin
         acc_ff[pix_data.bx] <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pix_ready) begin
         valid_ff <= pix_valid && pix_data.in_window && pix_data.last;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/boxdec_level.sv
// boxdec_level: block mean as rounded Q0.16 fraction of full scale by an
// exact reciprocal multiply; drives the result register. Depends on boxdec_pkg.
`default_nettype none

module boxdec_level import boxdec_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         blk_valid,
   output logic         blk_ready,
   input  blk_type      blk_data,
   boxdec_rsp_if.source rsp_ch
);

   logic [NUM_W-1:0]     num;
   logic [PROD_W-1:0]    prod;
   logic [QUOT_W-1:0]    quot;
   logic [LEVEL_W-1:0]   level_in, level_ff;
   logic                 valid_ff;
   blk_type              data_ff;

   assign blk_ready = !valid_ff || rsp_ch.ready;

   always_comb begin
      num  = {blk_data.block_sum, LEVEL_W'(0)} + NUM_W'(HALF_SCALE);
      prod = PROD_W'(num) * PROD_W'(RECIP);
      quot = prod[RECIP_SHIFT +: QUOT_W];
      // a full-scale block rounds to 1.0, held at the top code
      level_in = (quot > QUOT_W'({LEVEL_W{1'b1}})) ? '1 : LEVEL_W'(quot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (blk_ready) begin
         valid_ff <= blk_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (blk_ready) begin
         level_ff <= level_in;
         data_ff  <= blk_data;
      end
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.level         = level_ff;
   assign rsp_ch.block_sum     = data_ff.block_sum;
   assign rsp_ch.out_col       = data_ff.bx;
   assign rsp_ch.out_row       = data_ff.by;
   assign rsp_ch.last_of_frame = data_ff.last_of_frame;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// tb: self-checking bench for box_average_decimator_core, feeding raster pixels
// and checking every 5x5 block result against a behavioral predictor.
// Depends on boxdec_pkg, boxdec_req_if/boxdec_rsp_if and the core itself.
`default_nettype none

module tb;
   import boxdec_pkg::*;

   localparam int unsigned FLUSH_CYCLES = 20;

   typedef enum logic {ITEM_PIXEL, ITEM_SYNC} item_kind_type;

   typedef enum logic [2:0] {
      PIX_UNIFORM, PIX_EXTREME, PIX_HIGH, PIX_LOW, PIX_FULL, PIX_ZERO
   } pixel_mode_type;

   typedef struct {
      item_kind_type      kind;
      logic [PIXEL_W-1:0] pixel;
      logic               frame_start;
   } pixel_item_type;

   typedef struct {
      logic [LEVEL_W-1:0]   level;
      logic [SUM_W-1:0]     block_sum;
      logic [OUT_COL_W-1:0] out_col;
      logic [OUT_ROW_W-1:0] out_row;
      logic                 last_of_frame;
   } block_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   boxdec_req_if req_if ();
   boxdec_rsp_if rsp_if ();

   box_average_decimator_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   always #4 clock = ~clock;

   pixel_item_type   pending_pixels[$];
   block_result_type expected_blocks[$];

   // predictor state
   int unsigned col_pos;
   int unsigned row_pos;
   int unsigned block_acc[OUT_COLS];

   int unsigned gap_left;
   int unsigned gap_free_left;
   int unsigned hold_left;
   int unsigned ready_free_left;
   bit          end_flush;

   int unsigned error_count;
   int unsigned pixels_sent;
   int unsigned blocks_checked;
   int unsigned frame_ends;
   int unsigned saturated_blocks;
   int unsigned long_holds;
   int unsigned sync_points;

   function automatic logic [LEVEL_W-1:0] level_of_sum(input int unsigned sum);
      logic [63:0] q;
      q = ((64'(sum) << 16) + 64'(HALF_SCALE)) / 64'(FULL_SCALE);
      return (q > 64'd65535) ? 16'hFFFF : q[15:0];
   endfunction

   // accumulate one transferred pixel, queue a block result when it closes one
   function automatic void predict_block(input logic [PIXEL_W-1:0] px, input logic fs);
      block_result_type r;
      int unsigned      x, y, bx, by, ix, iy;
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      if (col_pos >= TRIM_X && row_pos >= TRIM_Y &&
          col_pos - TRIM_X < SPAN_X && row_pos - TRIM_Y < SPAN_Y) begin
         x  = col_pos - TRIM_X;
         y  = row_pos - TRIM_Y;
         bx = x / BLOCK_W;
         by = y / BLOCK_H;
         ix = x % BLOCK_W;
         iy = y % BLOCK_H;
         if (ix == 0 && iy == 0) block_acc[bx] = px;
         else block_acc[bx] = block_acc[bx] + px;
         if (ix == BLOCK_W - 1 && iy == BLOCK_H - 1) begin
            r.block_sum     = SUM_W'(block_acc[bx]);
            r.level         = level_of_sum(block_acc[bx]);
            r.out_col       = OUT_COL_W'(bx);
            r.out_row       = OUT_ROW_W'(by);
            r.last_of_frame = (bx == OUT_COLS - 1 && by == OUT_ROWS - 1);
            expected_blocks.push_back(r);
         end
      end
      col_pos++;
      if (col_pos >= IN_COLS) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= IN_ROWS) row_pos = 0;
      end
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   function automatic int unsigned next_gap();
      int unsigned r;
      if (gap_free_left != 0) begin
         gap_free_left--;
         return 0;
      end
      if ($urandom_range(0, 299) == 0) gap_free_left = $urandom_range(100, 600);
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 24);
   endfunction

   function automatic logic [PIXEL_W-1:0] gen_pixel(input pixel_mode_type mode);
      case (mode)
         PIX_FULL:    return 8'hFF;
         PIX_ZERO:    return 8'h00;
         PIX_HIGH:    return 8'($urandom_range(235, 255));
         PIX_LOW:     return 8'($urandom_range(0, 20));
         PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         default:     return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic push_pixel(input logic [PIXEL_W-1:0] px, input logic fs);
      pixel_item_type it;
      it.kind        = ITEM_PIXEL;
      it.pixel       = px;
      it.frame_start = fs;
      pending_pixels.push_back(it);
   endtask

   task automatic push_sync();
      pixel_item_type it;
      it.kind        = ITEM_SYNC;
      it.pixel       = '0;
      it.frame_start = 1'b0;
      pending_pixels.push_back(it);
   endtask

   task automatic add_run(input pixel_mode_type mode, input int unsigned count,
                          input bit with_start);
      for (int unsigned i = 0; i < count; i++)
         push_pixel(gen_pixel(mode), with_start && i == 0);
   endtask

   // pixel sender
   always @(posedge clock) begin : drive_proc
      pixel_item_type it;
      if (reset) begin
         req_if.valid       <= 1'b0;
         req_if.pixel       <= '0;
         req_if.frame_start <= 1'b0;
         gap_left           <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_block(req_if.pixel, req_if.frame_start);
            pixels_sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left != 0) begin
               req_if.valid <= 1'b0;
               gap_left     <= gap_left - 1;
            end else if (pending_pixels.size() != 0 && pending_pixels[0].kind == ITEM_SYNC) begin
               // hold off until every outstanding block has come back
               req_if.valid <= 1'b0;
               if (expected_blocks.size() == 0) begin
                  void'(pending_pixels.pop_front());
                  sync_points++;
               end
            end else if (pending_pixels.size() != 0) begin
               it                  = pending_pixels.pop_front();
               req_if.valid       <= 1'b1;
               req_if.pixel       <= it.pixel;
               req_if.frame_start <= it.frame_start;
               gap_left           <= next_gap();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result receiver backpressure
   always @(posedge clock) begin : ready_proc
      int unsigned r;
      if (reset) begin
         rsp_if.ready    <= 1'b0;
         hold_left       <= 0;
         ready_free_left <= 0;
      end else begin
         if (end_flush) begin
            rsp_if.ready <= 1'b1;
         end else if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
         end else if (long_holds == 0 && rsp_if.valid) begin
            // long stall on the first result so the pipe backs up into the pixel input
            rsp_if.ready <= 1'b0;
            hold_left    <= 400;
            long_holds++;
         end else if (ready_free_left != 0) begin
            rsp_if.ready    <= 1'b1;
            ready_free_left <= ready_free_left - 1;
         end else begin
            r = $urandom_range(0, 199);
            if (r == 0) begin
               rsp_if.ready    <= 1'b1;
               ready_free_left <= $urandom_range(200, 1000);
            end else if (r < 140) begin
               rsp_if.ready <= 1'b1;
            end else if (r < 190) begin
               rsp_if.ready <= 1'b0;
               hold_left    <= $urandom_range(0, 3);
            end else begin
               rsp_if.ready <= 1'b0;
               hold_left    <= $urandom_range(10, 40);
            end
         end
      end
   end

   // block result checker
   always @(posedge clock) begin : check_proc
      block_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_blocks.size() == 0) begin
            $display("%0t: unexpected block result, expected none, actual col %0d row %0d sum %0d",
                     $time, rsp_if.out_col, rsp_if.out_row, rsp_if.block_sum);
            error_count++;
         end else begin
            want = expected_blocks.pop_front();
            check_field("level", want.level, rsp_if.level);
            check_field("block_sum", want.block_sum, rsp_if.block_sum);
            check_field("out_col", want.out_col, rsp_if.out_col);
            check_field("out_row", want.out_row, rsp_if.out_row);
            check_field("last_of_frame", want.last_of_frame, rsp_if.last_of_frame);
            blocks_checked++;
            if (want.last_of_frame) frame_ends++;
            if (want.block_sum == FULL_SCALE) saturated_blocks++;
         end
      end
   end

   initial begin
      #400_000;
      $display("tb: FAIL");
      $finish;
   end

   initial begin : main_proc
      pixel_mode_type mode;
      int unsigned    len, col, bcol;

      end_flush = 1'b0;

      // short burst in the top border with frame_start scattered through it
      len = $urandom_range(10, 40);
      for (int unsigned i = 0; i < len; i++)
         push_pixel(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      // frame cut short inside the first block row, then restarted
      len = $urandom_range(170, 330);
      add_run(PIX_UNIFORM, len, 1'b1);
      // one complete block row, block columns cycling through the pixel modes;
      // the first pixels of each block overwrite what the cut frame left behind
      for (int unsigned i = 0; i < (TRIM_Y + BLOCK_H) * IN_COLS; i++) begin
         // pause for the outstanding blocks part way through the result stream
         if (i == (TRIM_Y + BLOCK_H - 1) * IN_COLS + IN_COLS / 2) push_sync();
         col  = i % IN_COLS;
         bcol = (col >= TRIM_X) ? (col - TRIM_X) / BLOCK_W : 0;
         mode = pixel_mode_type'(3'(bcol % 6));
         push_pixel(gen_pixel(mode), i == 0);
      end
      push_sync();
      // a few more pixels with frame starts mixed in
      len = $urandom_range(10, 40);
      for (int unsigned i = 0; i < len; i++)
         push_pixel(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_pixels.size() != 0 || req_if.valid) @(posedge clock);
      end_flush = 1'b1;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);

      $display("%0d pixels sent, %0d blocks checked (%0d full-scale, %0d frame ends)",
               pixels_sent, blocks_checked, saturated_blocks, frame_ends);
      $display("%0d long result stalls, %0d pauses for outstanding blocks, %0d errors",
               long_holds, sync_points, error_count);
      if (error_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: box_average_decimator_core.f
hdl/boxdec_pkg.sv
hdl/boxdec_if.sv
hdl/boxdec_position.sv
hdl/boxdec_accum.sv
hdl/boxdec_level.sv
hdl/box_average_decimator_core.sv
tb/sv/tb.sv
